### rtl/core/quadrature_encoder_poll_decoder_unit_defines.svh
// Assertion macros for the quadrature encoder poll decoder.
`ifndef QUADRATURE_ENCODER_POLL_DECODER_UNIT_DEFINES_SVH
`define QUADRATURE_ENCODER_POLL_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define QEPD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define QEPD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QEPD_ASSERT(label, prop, msg)
`define QEPD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### rtl/core/qepd_pkg.sv
`timescale 1ns / 1ps
package qepd_pkg;

	localparam int ShiftW   = 16;
	localparam int TrackerW = 9;
	localparam int TableW   = 32;
	localparam int SpcW     = 8;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 32;

	localparam logic [CfgIdxW-1:0] RegMode  = 2'd0;
	localparam logic [CfgIdxW-1:0] RegCw    = 2'd1;
	localparam logic [CfgIdxW-1:0] RegTable = 2'd2;
	localparam logic [CfgIdxW-1:0] RegSpc   = 2'd3;

	localparam logic              ModeDebounce = 1'b0;
	localparam logic              ModeTracker  = 1'b1;

	localparam logic [1:0]        CwRst    = 2'b01;
	localparam logic [TableW-1:0] TableRst = 32'h3443_C11C;
	localparam logic [SpcW-1:0]   SpcRst   = 8'd4;

	typedef logic signed [1:0] dir_t;

	typedef struct packed {
		logic              mode;
		logic [1:0]        cw_sign;
		logic [TableW-1:0] transition_table;
		logic [SpcW-1:0]   steps_per_count;
	} cfg_t;

endpackage

### rtl/core/quadrature_encoder_poll_decoder_unit.sv
`timescale 1ns / 1ps
// Pipeline: an accepted input is held in the input register, then its result is loaded
// into the result register, which drives out_valid and direction.
// Throughput: one sample per cycle; out_ready low on a held result stalls the pipeline.
// Reset: arst_n clears the pipeline, the debounce shift, previous AB and the tracker,
// and loads mode 0, cw sign +1, the standard transition table and steps_per_count 4.
`include "quadrature_encoder_poll_decoder_unit_defines.svh"
module quadrature_encoder_poll_decoder_unit
	import qepd_pkg::*;
#(
	parameter int DEBOUNCE_LEN = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                channel_a,
	input  logic                channel_b,
	output logic                out_valid,
	input  logic                out_ready,
	output dir_t                direction,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t cfg_q;
	logic valid_s1;
	logic a_s1;
	logic b_s1;
	logic valid_s2;
	dir_t dir_s2;
	dir_t dir_calc;
	logic advance;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign direction = dir_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode             <= ModeDebounce;
			cfg_q.cw_sign          <= CwRst;
			cfg_q.transition_table <= TableRst;
			cfg_q.steps_per_count  <= SpcRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegMode:  cfg_q.mode             <= cfg_data[0];
				RegCw:    cfg_q.cw_sign          <= cfg_data[1:0];
				RegTable: cfg_q.transition_table <= cfg_data[TableW-1:0];
				RegSpc:   cfg_q.steps_per_count  <= cfg_data[SpcW-1:0];
				default:  cfg_q.mode             <= cfg_q.mode;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			a_s1 <= channel_a;
			b_s1 <= channel_b;
		end
		if (advance) begin
			dir_s2 <= dir_calc;
		end
	end

	qepd_step #(
		.DEBOUNCE_LEN(DEBOUNCE_LEN)
	) u_step (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (advance),
		.a     (a_s1),
		.b     (b_s1),
		.cfg   (cfg_q),
		.dir   (dir_calc)
	);

	`QEPD_ASSERT(a_accept_fills_s1, (in_valid && in_ready) |=> valid_s1, "input lost")
	`QEPD_ASSERT(a_advance_fills_s2, advance |=> out_valid, "result not registered")
	`QEPD_ASSERT(a_drain, (out_valid && out_ready && !valid_s1) |=> !out_valid, "result repeated")
	`QEPD_ASSERT_ALWAYS(a_dir_range, out_valid |-> (direction != 2'sb10), "direction out of range")

endmodule

### rtl/core/qepd_step.sv
`timescale 1ns / 1ps
module qepd_step
	import qepd_pkg::*;
#(
	parameter int DEBOUNCE_LEN = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic a,
	input  logic b,
	input  cfg_t cfg,
	output dir_t dir
);

	localparam logic [ShiftW-1:0] ForcedOnes =
		ShiftW'((32'hFFFF << (DEBOUNCE_LEN + 1)) & 32'hFFFF);
	localparam logic [ShiftW-1:0] EdgePattern =
		ForcedOnes | ShiftW'(32'd1 << DEBOUNCE_LEN);

	logic [ShiftW-1:0]          debounce_q;
	logic [1:0]                 prev_ab_q;
	logic signed [TrackerW-1:0] tracker_q;

	logic [ShiftW-1:0]          debounce_d;
	logic [3:0]                 idx;
	logic signed [1:0]          entry;
	logic signed [1:0]          cw;
	logic signed [2:0]          prod;
	logic signed [TrackerW-1:0] sum;
	logic [TrackerW-1:0]        thr;
	logic [TrackerW-1:0]        thr_neg;
	logic                       hit;
	dir_t                       dir_deb;

	assign debounce_d = {debounce_q[ShiftW-2:0], a} | ForcedOnes;
	assign idx        = {prev_ab_q, a, b};
	assign entry      = cfg.transition_table[{idx, 1'b0} +: 2];

	always_comb begin
		unique case (cfg.cw_sign)
			2'b01:   cw = 2'sb01;
			2'b00:   cw = 2'sb00;
			default: cw = 2'sb11;
		endcase
	end

	always_comb begin
		unique case (cw)
			2'sb01:  prod = 3'(entry);
			2'sb00:  prod = 3'sb000;
			default: prod = -(3'(entry));
		endcase
	end

	assign sum     = tracker_q + TrackerW'(prod);
	assign thr     = (cfg.steps_per_count == '0) ? TrackerW'(1) : TrackerW'(cfg.steps_per_count);
	assign thr_neg = ~thr + TrackerW'(1);
	assign hit     = (sum == thr) || (sum == thr_neg);
	assign dir_deb = (debounce_d == EdgePattern) ? (b ? -cw : cw) : 2'sb00;

	always_comb begin
		if (cfg.mode == ModeDebounce) begin
			dir = dir_deb;
		end else if (hit) begin
			dir = sum[TrackerW-1] ? 2'sb11 : 2'sb01;
		end else begin
			dir = 2'sb00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= '0;
			prev_ab_q  <= '0;
			tracker_q  <= '0;
		end else if (en) begin
			if (cfg.mode == ModeDebounce) begin
				debounce_q <= debounce_d;
			end else begin
				prev_ab_q <= {a, b};
				tracker_q <= hit ? '0 : sum;
			end
		end
	end

endmodule

### bench/tb_quadrature_encoder_poll_decoder_unit.sv
`timescale 1ns / 1ps
module tb_quadrature_encoder_poll_decoder_unit;
	import qepd_pkg::*;

	localparam int DebounceLen = 12;
	localparam int NumPhases   = 12;
	localparam logic [ShiftW-1:0] ForcedOnes   = ShiftW'(16'hFFFF << (DebounceLen + 1));
	localparam logic [ShiftW-1:0] PulsePattern = ForcedOnes | ShiftW'(1 << DebounceLen);

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic                channel_a = 1'b0;
	logic                channel_b = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	dir_t                direction;
	logic                cfg_we    = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data  = '0;

	quadrature_encoder_poll_decoder_unit #(
		.DEBOUNCE_LEN(DebounceLen)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.channel_a(channel_a),
		.channel_b(channel_b),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.direction(direction),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	class direction_book;
		logic                       mode;
		logic [1:0]                 cw_dir;
		logic [TableW-1:0]          step_table;
		logic [SpcW-1:0]            spc;
		logic [ShiftW-1:0]          shift_reg;
		logic [1:0]                 prev_ab;
		logic signed [TrackerW-1:0] tracker;
		dir_t                       pending_dirs[$];
		int                         mismatches;

		function new();
			mode       = ModeDebounce;
			cw_dir     = CwRst;
			step_table = TableRst;
			spc        = SpcRst;
			shift_reg  = '0;
			prev_ab    = '0;
			tracker    = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
			case (idx)
				RegMode:  mode       = data[0];
				RegCw:    cw_dir     = data[1:0];
				RegTable: step_table = data[TableW-1:0];
				RegSpc:   spc        = data[SpcW-1:0];
				default: ;
			endcase
		endfunction

		function dir_t decode_sample(logic a, logic b);
			int         cw;
			int         entry;
			int         thr;
			int         level;
			logic [3:0] idx;
			logic [1:0] raw;
			dir_t       d;
			cw = (cw_dir == 2'b01) ? 1 : (cw_dir == 2'b00) ? 0 : -1;
			d  = 2'sd0;
			if (mode == ModeDebounce) begin
				shift_reg = {shift_reg[ShiftW-2:0], a} | ForcedOnes;
				if (shift_reg == PulsePattern)
					d = dir_t'(b ? -cw : cw);
			end else begin
				idx     = {prev_ab, a, b};
				raw     = step_table[2 * idx +: 2];
				entry   = $signed(raw);
				thr     = (spc == 0) ? 1 : int'(spc);
				tracker = tracker + TrackerW'(entry * cw);
				level   = tracker;
				prev_ab = {a, b};
				if (level == thr || level == -thr) begin
					d       = (level > 0) ? 2'sd1 : -2'sd1;
					tracker = '0;
				end
			end
			return d;
		endfunction

		function void note_sample(logic a, logic b);
			pending_dirs.push_back(decode_sample(a, b));
		endfunction

		function void check_direction(dir_t got);
			dir_t want;
			if (pending_dirs.size() == 0) begin
				$error("direction: expected none, actual %0d", got);
				mismatches++;
				return;
			end
			want = pending_dirs.pop_front();
			if (got !== want) begin
				$error("direction: expected %0d, actual %0d", want, got);
				mismatches++;
			end
		endfunction
	endclass

	direction_book book = new();
	bit            quiet = 1'b0;
	int            sent = 0;
	int            gray_pos = 0;
	int unsigned   stall_left = 0;
	logic [1:0]    gray_code [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL quadrature_encoder_poll_decoder_unit");
		$finish;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			book.check_direction(direction);
		if (stall_left != 0)
			stall_left--;
		else if (!quiet && $urandom_range(0, 11) == 0)
			stall_left = $urandom_range(1, 17);
		out_ready <= (stall_left == 0);
	end

	task automatic send_sample(input logic a, input logic b);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		channel_a <= a;
		channel_b <= b;
		do @(posedge clk); while (!in_ready);
		book.note_sample(a, b);
		sent++;
	endtask

	task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		book.write_reg(idx, data);
	endtask

	task automatic load_config(input logic m, input logic [1:0] cw,
			input logic [TableW-1:0] tbl, input logic [SpcW-1:0] s);
		put_reg(RegMode, (32'($urandom()) & ~32'h1) | 32'(m));
		put_reg(RegCw, (32'($urandom()) & ~32'h3) | 32'(cw));
		put_reg(RegTable, tbl);
		put_reg(RegSpc, (32'($urandom()) & ~32'hFF) | 32'(s));
		cfg_we <= 1'b0;
	endtask

	// hold input low until every transaction has returned, then let the pipe drain
	task automatic settle();
		in_valid <= 1'b0;
		while (book.pending_dirs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic turn(input bit fwd);
		gray_pos = fwd ? (gray_pos + 1) % 4 : (gray_pos + 3) % 4;
		send_sample(gray_code[gray_pos][1], gray_code[gray_pos][0]);
	endtask

	task automatic debounce_run();
		int highs;
		int lows;
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 8))
				send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end else begin
			highs = $urandom_range(1, 4);
			lows  = ($urandom_range(0, 3) != 0) ? DebounceLen : $urandom_range(0, 16);
			repeat (highs) send_sample(1'b1, 1'($urandom_range(0, 1)));
			repeat (lows) send_sample(1'b0, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic tracker_run(input int reach);
		int steps;
		bit fwd;
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 6)) begin
				gray_pos = $urandom_range(0, 3);
				send_sample(gray_code[gray_pos][1], gray_code[gray_pos][0]);
			end
		end else begin
			steps = $urandom_range(1, 2 * reach + 4);
			fwd   = 1'($urandom_range(0, 1));
			repeat (steps) begin
				if ($urandom_range(0, 9) != 0)
					turn(fwd);
				else
					send_sample(gray_code[gray_pos][1], gray_code[gray_pos][0]);
			end
		end
	endtask

	initial begin
		logic              m;
		logic [1:0]        cw;
		logic [TableW-1:0] tbl;
		logic [SpcW-1:0]   s;
		int                target;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(1'b1, 1'b0);
		repeat (DebounceLen - 1) send_sample(1'b0, 1'b0);
		send_sample(1'b0, 1'b1);
		settle();

		load_config(ModeTracker, 2'b10, TableRst, 8'd0);
		repeat (4) turn(1'b1);
		settle();

		load_config(ModeTracker, 2'b00, 32'hAAAA_AAAA, 8'd255);
		repeat (3) turn(1'b0);
		settle();

		load_config(ModeDebounce, 2'b11, 32'hFFFF_FFFF, 8'd1);
		send_sample(1'b1, 1'b1);
		repeat (3) send_sample(1'b0, 1'b0);
		settle();

		for (int ph = 0; ph < NumPhases; ph++) begin
			quiet = (ph == NumPhases - 1);
			m     = (ph % 2 == 1) ? ModeTracker : ModeDebounce;
			cw    = 2'($urandom_range(0, 3));
			case (ph % 5)
				0: s = 8'd1;
				1: s = 8'd255;
				2: s = 8'd0;
				default: s = 8'($urandom_range(2, 8));
			endcase
			case ($urandom_range(0, 5))
				0: tbl = TableRst;
				1: tbl = 32'hAAAA_AAAA;
				2: tbl = 32'h5555_5555;
				3: tbl = 32'hFFFF_FFFF;
				4: tbl = 32'h0000_0000;
				default: tbl = 32'($urandom());
			endcase
			if (ph == 1)
				tbl = TableRst;
			load_config(m, cw, tbl, s);
			target = sent + ((m == ModeTracker && s == 8'd255) ? 400 : 100);
			while (sent < target) begin
				if (m == ModeDebounce)
					debounce_run();
				else
					tracker_run((s == 0) ? 1 : int'(s));
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (book.mismatches == 0 && book.pending_dirs.size() == 0)
			$display("PASS quadrature_encoder_poll_decoder_unit");
		else
			$display("FAIL quadrature_encoder_poll_decoder_unit");
		$finish;
	end

endmodule
